// ===== hw/rtl/ip_wildcard_ban_table_top_defines.svh =====
// ============================================================================
// ip_wildcard_ban_table_top_defines.svh
// Assertion macros shared by the ban table RTL.
// ============================================================================
`ifndef IP_WILDCARD_BAN_TABLE_TOP_DEFINES_SVH
`define IP_WILDCARD_BAN_TABLE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define IPWB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define IPWB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ipwb_pkg.sv =====
// ============================================================================
// ipwb_pkg
// Types, codes and the wildcard match function for the IPv4 ban table.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ipwb_pkg;

    localparam logic [7:0] WILD_OCTET = 8'hFF;

    typedef enum logic [1:0] {
        CMD_CHECK  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAN_ALL = 2'd1,
        ST_ZERO    = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_PEND
    } fsm_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic    banned;
        status_t status;
    } resp_t;

    // request token walking the cell chain
    typedef struct packed {
        logic        active;
        cmd_t        command;
        logic [31:0] address;
        logic        hit;      // check matched a live pattern
        logic        found;    // exact live match seen
        logic        claimed;  // a free entry has been reserved
    } tok_t;

    // octets compared first to last; a pattern octet of 0xFF matches the rest
    function automatic logic pattern_matches(input logic [31:0] pat,
                                             input logic [31:0] addr);
        logic res;
        logic done;
        res  = 1'b1;
        done = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (!done) begin
                if (pat[31-8*k -: 8] == WILD_OCTET) begin
                    res  = 1'b1;
                    done = 1'b1;
                end else if (pat[31-8*k -: 8] != addr[31-8*k -: 8]) begin
                    res  = 1'b0;
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipwb_cell.sv =====
// ============================================================================
// ipwb_cell
// One table entry: stored pattern, live bit and a slot reservation mark.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ipwb_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire ipwb_pkg::tok_t tok_i,
    input  wire logic          commit_i,
    output ipwb_pkg::tok_t     tok_o,
    output logic               mark_o
);

    logic [31:0]    pattern_reg, pattern_next;
    logic           valid_reg, valid_next;
    logic           mark_reg, mark_next;
    ipwb_pkg::tok_t tok_reg, tok_next;
    logic           eq;

    assign eq = (pattern_reg == tok_i.address);

    always_comb begin
        tok_next     = tok_i;
        pattern_next = pattern_reg;
        valid_next   = valid_reg;
        mark_next    = mark_reg;
        if (commit_i && mark_reg) begin
            valid_next = 1'b1;
        end
        if (tok_i.active) begin
            mark_next = 1'b0;
            case (tok_i.command)
                ipwb_pkg::CMD_CHECK: begin
                    if (valid_reg && ipwb_pkg::pattern_matches(pattern_reg, tok_i.address)) begin
                        tok_next.hit = 1'b1;
                    end
                end
                ipwb_pkg::CMD_ADD: begin
                    if (valid_reg && eq) begin
                        tok_next.found = 1'b1;
                    end
                    // free entry content is don't-care, so write it now
                    if (!valid_reg && !tok_i.claimed) begin
                        pattern_next     = tok_i.address;
                        mark_next        = 1'b1;
                        tok_next.claimed = 1'b1;
                    end
                end
                ipwb_pkg::CMD_REMOVE: begin
                    if (valid_reg && eq && !tok_i.found) begin
                        valid_next     = 1'b0;
                        tok_next.found = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        pattern_reg <= pattern_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            mark_reg       <= 1'b0;
            tok_reg.active <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_o  = tok_reg;
    assign mark_o = mark_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ip_wildcard_ban_table_top.sv =====
// ============================================================================
// ip_wildcard_ban_table_top
// IPv4 wildcard ban table: check, add and remove requests over a cell chain.
// ============================================================================
//
//  Channel | Ports                        | Direction | Contents
//  --------+------------------------------+-----------+---------------------
//  request | s_valid, s_ready, s_req      | in        | command, address
//  result  | m_valid, m_ready, m_resp     | out       | banned, status
//
//  From acceptance to result: cell 0 takes the token at the accepting edge, the
//  token passes through each cell in turn, res_reg stages the result as it
//  leaves the last cell, and it is loaded into the output register once that
//  register is free.
//  One request is in the table at a time; s_ready is high only when idle, so
//  the next request is taken no sooner than the cycle after the result loads.
//  Reset (aresetn, synchronous, active low) clears all live bits and control.
//  A stalled result holds the next request's result in a pending stage.
//
`timescale 1ns / 1ps
`default_nettype none

`include "ip_wildcard_ban_table_top_defines.svh"

module ip_wildcard_ban_table_top #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // request channel
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ipwb_pkg::req_t   s_req,
    // result channel
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ipwb_pkg::resp_t       m_resp
);

    // chain[0] is the injected token, chain[i+1] the output of cell i
    ipwb_pkg::tok_t             chain [TABLE_ENTRIES+1];
    ipwb_pkg::tok_t             tail;
    logic [TABLE_ENTRIES-1:0]   mark_vec;
    logic [TABLE_ENTRIES-1:0]   act_vec;

    ipwb_pkg::fsm_t  state_reg, state_next;
    ipwb_pkg::resp_t res_reg, res_next;
    ipwb_pkg::resp_t m_resp_reg, m_resp_next;
    logic            m_valid_reg, m_valid_next;

    logic            accept;
    logic            commit;
    logic            load_out;
    logic            add_ok;      // add passes the first-octet and zero checks
    ipwb_pkg::resp_t tail_resp;

    assign accept = s_valid && s_ready;

    // token enters cell 0 directly in the accept cycle
    always_comb begin
        chain[0]         = '0;
        chain[0].active  = accept;
        chain[0].command = s_req.command;
        chain[0].address = s_req.address;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            ipwb_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .tok_i    (chain[gi]),
                .commit_i (commit),
                .tok_o    (chain[gi+1]),
                .mark_o   (mark_vec[gi])
            );
            assign act_vec[gi] = chain[gi+1].active;
        end
    endgenerate

    assign tail = chain[TABLE_ENTRIES];

    assign add_ok = (tail.address[31:24] != ipwb_pkg::WILD_OCTET) && (tail.address != '0);

    // result of the request leaving the chain
    always_comb begin
        tail_resp        = '0;
        tail_resp.banned = (tail.command == ipwb_pkg::CMD_CHECK) && tail.hit;
        tail_resp.status = ipwb_pkg::ST_OK;
        if (tail.command == ipwb_pkg::CMD_ADD) begin
            if (tail.address[31:24] == ipwb_pkg::WILD_OCTET) begin
                tail_resp.status = ipwb_pkg::ST_BAN_ALL;
            end else if (tail.address == '0) begin
                tail_resp.status = ipwb_pkg::ST_ZERO;
            end else if (!tail.found && !tail.claimed) begin
                tail_resp.status = ipwb_pkg::ST_FULL;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ipwb_pkg::FSM_IDLE: begin
                if (accept) begin
                    state_next = ipwb_pkg::FSM_SCAN;
                end
            end
            ipwb_pkg::FSM_SCAN: begin
                if (tail.active) begin
                    state_next = ipwb_pkg::FSM_PEND;
                end
            end
            ipwb_pkg::FSM_PEND: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ipwb_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = ipwb_pkg::FSM_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        s_ready      = 1'b0;
        commit       = 1'b0;
        load_out     = 1'b0;
        res_next     = res_reg;
        unique case (state_reg)
            ipwb_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
            end
            ipwb_pkg::FSM_SCAN: begin
                if (tail.active) begin
                    res_next = tail_resp;
                    // reserved free entry goes live only for a new, legal pattern
                    commit   = (tail.command == ipwb_pkg::CMD_ADD) && add_ok &&
                               !tail.found && tail.claimed;
                end
            end
            ipwb_pkg::FSM_PEND: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_resp_next  = m_resp_reg;
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_resp_next  = res_reg;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_resp_reg <= m_resp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ipwb_pkg::FSM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_resp  = m_resp_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // stale marks of an earlier request are cleared as the token passes, so
    // only once the token reaches the tail is a single mark guaranteed
    `IPWB_ASSERT_IMP(a_single_token, 1'b1, $countones(act_vec) <= 1,
                     "more than one request in the cell chain")
    `IPWB_ASSERT_IMP(a_single_mark, tail.active, $countones(mark_vec) <= 1,
                     "more than one entry reserved")
    `IPWB_ASSERT_IMP(a_tail_in_scan, tail.active, state_reg == ipwb_pkg::FSM_SCAN,
                     "request left the chain outside a scan")
    `IPWB_ASSERT_NXT(a_commit_pend, commit, state_reg == ipwb_pkg::FSM_PEND,
                     "entry commit not followed by result staging")

endmodule

`default_nettype wire

// ===== tb/ip_wildcard_ban_table_top_tb.sv =====
// ============================================================================
// ip_wildcard_ban_table_top_tb
// Self-checking bench for the IPv4 wildcard ban table. A queue of check, add,
// remove and no-op requests feeds a bursty driver. A table model in the bench
// predicts each result when the request is accepted. A monitor behind a
// stalling receiver compares every result, field by field, with the model.
// ============================================================================
`timescale 1ns / 1ps

module ip_wildcard_ban_table_top_tb;

    localparam int TABLE_ENTRIES  = 32;
    localparam int REQ_LATENCY    = TABLE_ENTRIES + 2;
    // cycles with no handshake on either side before we give up
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 75;

    // expectation carries its request so a mismatch can say what was asked
    typedef struct packed {
        ipwb_pkg::req_t  req;
        ipwb_pkg::resp_t resp;
    } verdict_t;

    logic            aclk;
    logic            aresetn;
    logic            s_valid = 1'b0;
    logic            s_ready;
    ipwb_pkg::req_t  s_req   = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    ipwb_pkg::resp_t m_resp;

    ipwb_pkg::req_t request_q[$];   // requests not yet handed to the driver
    verdict_t       verdict_q[$];   // predicted results, oldest first
    int             mismatches   = 0;
    int             quiet_cycles = 0;

    // bench copy of the table
    bit [31:0] ban_pat  [TABLE_ENTRIES] = '{default: '0};
    bit        ban_live [TABLE_ENTRIES] = '{default: 1'b0};

    ip_wildcard_ban_table_top #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_resp  (m_resp)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------------

    // The octets ahead of the first wildcard must agree; everything from the
    // wildcard on is don't-care. A client octet of 0xFF matches only from the
    // wildcard on, since no pattern octet ahead of the wildcard is 0xFF.
    function automatic bit prefix_hit(input logic [31:0] pat, input logic [31:0] addr);
        logic [31:0] care;
        bit          open_tail;
        care      = '0;
        open_tail = 1'b0;
        for (int j = 0; j < 4; j++) begin
            if (pat[31-8*j -: 8] == ipwb_pkg::WILD_OCTET)
                open_tail = 1'b1;
            if (!open_tail)
                care[31-8*j -: 8] = 8'hFF;
        end
        return ((pat ^ addr) & care) == '0;
    endfunction

    // Applies one request to the model table and returns its result.
    function automatic ipwb_pkg::resp_t ban_table_apply(input ipwb_pkg::req_t rq);
        ipwb_pkg::resp_t r;
        int              exact_idx;
        int              free_idx;
        r.banned  = 1'b0;
        r.status  = ipwb_pkg::ST_OK;
        exact_idx = -1;
        free_idx  = -1;
        // walk downward so both indexes end on the lowest qualifying entry
        for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
            if (ban_live[e] && ban_pat[e] == rq.address)
                exact_idx = e;
            if (!ban_live[e])
                free_idx = e;
        end
        case (rq.command)
            ipwb_pkg::CMD_CHECK: begin
                for (int e = 0; e < TABLE_ENTRIES; e++)
                    if (ban_live[e] && prefix_hit(ban_pat[e], rq.address))
                        r.banned = 1'b1;
            end
            ipwb_pkg::CMD_ADD: begin
                if (rq.address[31:24] == ipwb_pkg::WILD_OCTET) begin
                    r.status = ipwb_pkg::ST_BAN_ALL;
                end else if (rq.address == '0) begin
                    r.status = ipwb_pkg::ST_ZERO;
                end else if (exact_idx < 0) begin
                    // duplicates fall through untouched with ST_OK
                    if (free_idx < 0) begin
                        r.status = ipwb_pkg::ST_FULL;
                    end else begin
                        ban_pat[free_idx]  = rq.address;
                        ban_live[free_idx] = 1'b1;
                    end
                end
            end
            ipwb_pkg::CMD_REMOVE: begin
                if (exact_idx >= 0)
                    ban_live[exact_idx] = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_req(input ipwb_pkg::cmd_t c, input logic [31:0] a);
        ipwb_pkg::req_t rq;
        rq.command = c;
        rq.address = a;
        request_q.push_back(rq);
    endtask

    // Client address that matches the pattern's fixed prefix, then sometimes
    // spoiled by a flipped bit or a 0xFF octet to land near a miss.
    function automatic logic [31:0] client_near(input logic [31:0] pat);
        logic [31:0] a;
        bit          past_wild;
        int          b;
        a         = $urandom;
        past_wild = 1'b0;
        for (int j = 0; j < 4; j++) begin
            if (pat[31-8*j -: 8] == ipwb_pkg::WILD_OCTET)
                past_wild = 1'b1;
            if (!past_wild)
                a[31-8*j -: 8] = pat[31-8*j -: 8];
        end
        case ($urandom_range(0, 3))
            0: begin
                b    = $urandom_range(0, 31);
                a[b] = ~a[b];
            end
            1: a[8*$urandom_range(0, 3) +: 8] = ipwb_pkg::WILD_OCTET;
            default: ;
        endcase
        return a;
    endfunction

    // Sampled at the falling edge so the driver's and predictor's updates
    // from the last rising edge have settled.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (request_q.size() != 0 || s_valid || verdict_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Reset and stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] pool[$];
        logic [31:0] p;
        int          add_pct [RANDOM_PHASES] = '{85, 20, 60, 15, 70, 30};
        int          fresh_n [RANDOM_PHASES] = '{56, 10, 30, 12, 40, 10};
        int          r;

        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: corner cases of matching and of the add rules.
        push_req(ipwb_pkg::CMD_CHECK,  32'h01020304);   // empty table never bans
        push_req(ipwb_pkg::CMD_ADD,    32'hFF000000);   // ban everyone rejected
        push_req(ipwb_pkg::CMD_ADD,    32'hFFFFFFFF);   // same, all ones
        push_req(ipwb_pkg::CMD_ADD,    32'h00000000);   // all-zero rejected
        push_req(ipwb_pkg::CMD_CHECK,  32'h00000000);
        push_req(ipwb_pkg::CMD_ADD,    32'h0A00FF07);   // wildcard with junk tail octet
        push_req(ipwb_pkg::CMD_CHECK,  32'h0A000102);   // hit through the wildcard
        push_req(ipwb_pkg::CMD_CHECK,  32'h0A010102);   // miss ahead of the wildcard
        push_req(ipwb_pkg::CMD_ADD,    32'h0A00FF07);   // duplicate add, no change
        push_req(ipwb_pkg::CMD_ADD,    32'hC0A80105);   // exact pattern
        push_req(ipwb_pkg::CMD_CHECK,  32'hC0A80105);
        push_req(ipwb_pkg::CMD_CHECK,  32'hC0A801FF);   // client 0xFF octet is no match
        push_req(ipwb_pkg::CMD_REMOVE, 32'h0A00FF09);   // differs only in tail: absent
        push_req(ipwb_pkg::CMD_CHECK,  32'h0A00FFFF);
        push_req(ipwb_pkg::CMD_REMOVE, 32'h0A00FF07);   // exact removal
        push_req(ipwb_pkg::CMD_CHECK,  32'h0A000102);   // wildcard entry gone
        push_req(ipwb_pkg::CMD_REMOVE, 32'h0A00FF07);   // second removal is a no-op
        push_req(ipwb_pkg::CMD_NOP,    32'hFFFFFFFF);   // unused command
        push_req(ipwb_pkg::CMD_NOP,    32'h00000000);
        push_req(ipwb_pkg::CMD_ADD,    32'h00000001);   // leading zero octet is legal
        push_req(ipwb_pkg::CMD_ADD,    32'hFEFFFFFF);   // widest legal wildcard
        push_req(ipwb_pkg::CMD_CHECK,  32'hFE123456);
        push_req(ipwb_pkg::CMD_CHECK,  32'hFFFFFFFF);
        push_req(ipwb_pkg::CMD_CHECK,  32'h00000001);
        // hold the sender until the table has answered everything
        wait_drained();

        // Random: a growing pool of patterns so adds collide, removes hit and
        // checks land on and near stored prefixes. Add-heavy phases fill the
        // table; remove/check-heavy phases empty it again.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int i = 0; i < fresh_n[ph]; i++) begin
                p = $urandom;
                r = $urandom_range(1, 7);
                if (r < 4)
                    p[31-8*r -: 8] = ipwb_pkg::WILD_OCTET;
                if ($urandom_range(0, 19) == 0)
                    p[31:24] = ipwb_pkg::WILD_OCTET;
                if ($urandom_range(0, 29) == 0)
                    p = '0;
                pool.push_back(p);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                p = pool[$urandom_range(0, pool.size() - 1)];
                r = $urandom_range(0, 99);
                if (r < add_pct[ph])
                    push_req(ipwb_pkg::CMD_ADD, p);
                else if (r < add_pct[ph] + 15)
                    push_req(ipwb_pkg::CMD_REMOVE,
                             ($urandom_range(0, 4) == 0) ? $urandom : p);
                else if (r < 97)
                    push_req(ipwb_pkg::CMD_CHECK,
                             $urandom_range(0, 1) ? client_near(p) : $urandom);
                else
                    push_req(ipwb_pkg::CMD_NOP, $urandom);
            end
            if (ph == 2)
                wait_drained();
        end

        wait_drained();
        repeat (3 * REQ_LATENCY) @(posedge aclk);
        mismatches += verdict_q.size();
        if (mismatches == 0)
            $display("ip_wildcard_ban_table_top_tb: done, clean");
        else
            $display("ip_wildcard_ban_table_top_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of back-to-back requests with random gaps between them.
    // The gap counter only runs while the channel is free, so gaps land at
    // varying points of the table walk.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_req      <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (request_q.size() != 0) begin
                s_req   <= request_q.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // predict at acceptance; the table takes one request at a time
    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn && s_valid && s_ready) begin
            v.req  = s_req;
            v.resp = ban_table_apply(s_req);
            verdict_q.push_back(v);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: rotates through always-ready, coin-flip, sparse and mostly
    // ready stretches.
    // ------------------------------------------------------------------------
    int stall_cyc = 0;

    always @(posedge aclk) begin
        stall_cyc++;
        case ((stall_cyc / 700) % 4)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= (stall_cyc % 5) == 0;
            default: m_ready <= $urandom_range(0, 7) != 0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with no request pending: banned %0d status %s",
                             $realtime, m_resp.banned, m_resp.status.name());
            end else begin
                v = verdict_q.pop_front();
                if (m_resp.banned !== v.resp.banned) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] %s %h: banned expected %0d, got %0d",
                                 $realtime, v.req.command.name(), v.req.address,
                                 v.resp.banned, m_resp.banned);
                end
                if (m_resp.status !== v.resp.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] %s %h: status expected %s, got %0d",
                                 $realtime, v.req.command.name(), v.req.address,
                                 v.resp.status.name(), m_resp.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run with errors when both channels go quiet.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ip_wildcard_ban_table_top_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
